[rtl/multichannel_conv3x3_accumulate_unit_defines.svh]
// Assertion macros for the multichannel 3x3 convolution accumulator.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef MULTICHANNEL_CONV3X3_ACCUMULATE_UNIT_DEFINES_SVH
`define MULTICHANNEL_CONV3X3_ACCUMULATE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define CMAC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cmac check failed");

// Next-cycle implication, disabled while reset is asserted
`define CMAC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cmac check failed");

`endif

[rtl/cmac_pkg.sv]
// Package for the multichannel 3x3 convolution accumulator: sizes, field
// widths, mode and register codes, saturation helpers. No dependencies.
package cmac_pkg;

  localparam int MAX_SIZE    = 256;
  localparam int TAPS        = 3;
  localparam int NTAP        = TAPS * TAPS;
  localparam int PIX_W       = 16;
  localparam int ACC_W       = 32;
  localparam int PROD_W      = 2 * PIX_W;
  localparam int PSUM_W      = PROD_W + 4;
  localparam int SUM_W       = PSUM_W + 1;
  localparam int POS_W       = 9;
  localparam int COORD_W     = $clog2(MAX_SIZE);
  localparam int SIZE_W      = 9;
  localparam int COUNT_W     = 10;
  localparam int MODE_W      = 2;
  localparam int LB_DEPTH    = MAX_SIZE + 2;
  localparam int LB_AW       = $clog2(LB_DEPTH);
  localparam int ACC_DEPTH   = MAX_SIZE * MAX_SIZE;
  localparam int ACC_AW      = $clog2(ACC_DEPTH);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 10;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 48;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(224);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

  // Item kinds carried in tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_PRELOAD = 2'd0,
    MODE_WEIGHT  = 2'd1,
    MODE_PIXEL   = 2'd2
  } mode_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_SIZE  = 1'b0,
    REG_PLANE_COUNT = 1'b1
  } cfg_reg_t;

  // Clamp a 32-bit two's complement value to 16 bits
  function automatic logic signed [PIX_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
    logic fits;
    fits = (&v[ACC_W-1:PIX_W-1]) || !(|v[ACC_W-1:PIX_W-1]);
    if (fits) return v[PIX_W-1:0];
    return v[ACC_W-1] ? {1'b1, {(PIX_W-1){1'b0}}} : {1'b0, {(PIX_W-1){1'b1}}};
  endfunction

  // Clamp the accumulator sum to 32 bits
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
    logic fits;
    fits = (&v[SUM_W-1:ACC_W-1]) || !(|v[SUM_W-1:ACC_W-1]);
    if (fits) return v[ACC_W-1:0];
    return v[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
  endfunction

endpackage

[rtl/cmac_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module cmac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/multichannel_conv3x3_accumulate_unit.sv]
// Top level of the multichannel 3x3 convolution accumulator.
// Depends on cmac_pkg, cmac_ram and multichannel_conv3x3_accumulate_unit_defines.svh.
`include "multichannel_conv3x3_accumulate_unit_defines.svh"

// Takes one request per clock: an accumulator preload, a kernel weight or a
// padded pixel in raster order, and every complete 3x3 window adds its nine
// products into the 16-bit-addressed accumulator RAM and returns the new
// saturated Q16.16 value with its interior position. A result moves through
// the stage registers into the output register. The input side stalls
// only when a finished result in the last stage finds the output register
// still full; until then requests keep flowing behind a waiting result. The
// two line buffers share one 258-entry RAM and the accumulators one
// 65536-entry RAM; both are read in the stage before their use and written back by the
// pipeline, with forwarding between neighboring requests, and neither is
// cleared after reset: an accumulator entry must be preloaded before the
// first plane of a run touches it.
module multichannel_conv3x3_accumulate_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // row [8:0], col [17:9], value [49:18], zero [55:50]
  input  logic [cmac_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode [1:0]
  input  logic [cmac_pkg::MODE_W-1:0]      in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_row [7:0], out_col [15:8], acc_value [47:16]
  output logic [cmac_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast,
  input  logic                             cfg_wr_en,
  input  logic [cmac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cmac_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import cmac_pkg::*;

  // Configuration
  logic [SIZE_W-1:0]  plane_size_r;
  logic [COUNT_W-1:0] plane_count_r;
  logic [SIZE_W-1:0]  size_eff;
  logic [SIZE_W-1:0]  size_p1;
  logic [COUNT_W-1:0] count_eff;

  // Pipeline control
  logic adv;

  // Input unpack
  logic [POS_W-1:0]        in_row;
  logic [POS_W-1:0]        in_col;
  logic signed [ACC_W-1:0] in_value;

  // Stage 1
  logic                    s1_vld_r;
  mode_t                   s1_mode_r;
  logic [POS_W-1:0]        s1_row_r;
  logic [POS_W-1:0]        s1_col_r;
  logic signed [ACC_W-1:0] s1_value_r;
  logic                    s1_fwd_r;
  logic [2*PIX_W-1:0]      s1_fwd_data_r;
  logic signed [PIX_W-1:0] s1_pix;
  logic                    s1_in_range;
  logic                    s1_pix_ok;
  logic                    s1_wt_ok;
  logic                    s1_pre_ok;
  logic                    s1_win;
  logic                    s1_done_plane;
  logic                    s1_is_last;
  logic [COUNT_W:0]        planes_inc;
  logic [POS_W-1:0]        s1_arow;
  logic [POS_W-1:0]        s1_acol;
  logic [2*PIX_W-1:0]      lb_rd;
  logic signed [PIX_W-1:0] lb_top;
  logic signed [PIX_W-1:0] lb_mid;

  // Line buffer RAM
  logic                    lb_we;
  logic [LB_AW-1:0]        lb_waddr;
  logic [2*PIX_W-1:0]      lb_wdata;
  logic [2*PIX_W-1:0]      lb_rdata;

  // Sequential state
  logic signed [PIX_W-1:0] weights_r [NTAP];
  logic signed [PIX_W-1:0] win_r [NTAP];
  logic [COUNT_W-1:0]      planes_done_r;

  // Stage 2
  logic                    s2_res_r;
  logic                    s2_pre_r;
  logic [COORD_W-1:0]      s2_row_r;
  logic [COORD_W-1:0]      s2_col_r;
  logic signed [ACC_W-1:0] s2_pre_val_r;
  logic                    s2_last_r;
  logic signed [PROD_W-1:0] s2_prod [NTAP];

  // Stage 3
  logic                     s3_res_r;
  logic                     s3_pre_r;
  logic [COORD_W-1:0]       s3_row_r;
  logic [COORD_W-1:0]       s3_col_r;
  logic signed [ACC_W-1:0]  s3_pre_val_r;
  logic                     s3_last_r;
  logic signed [PROD_W-1:0] s3_prod_r [NTAP];
  logic                     s3_fwd_r;
  logic signed [ACC_W-1:0]  s3_fwd_data_r;
  logic signed [PSUM_W-1:0] s3_psum;
  logic signed [ACC_W-1:0]  s3_acc_cur;

  // Stage 4
  logic                     s4_res_r;
  logic                     s4_pre_r;
  logic [COORD_W-1:0]       s4_row_r;
  logic [COORD_W-1:0]       s4_col_r;
  logic signed [ACC_W-1:0]  s4_pre_val_r;
  logic                     s4_last_r;
  logic signed [PSUM_W-1:0] s4_psum_r;
  logic signed [ACC_W-1:0]  s4_acc_old_r;
  logic signed [SUM_W-1:0]  s4_total;
  logic signed [ACC_W-1:0]  s4_acc_new;

  // Accumulator RAM
  logic                     acc_we;
  logic [ACC_AW-1:0]        acc_waddr;
  logic [ACC_W-1:0]         acc_wdata;
  logic [ACC_AW-1:0]        acc_raddr;
  logic [ACC_W-1:0]         acc_rdata;

  // Output register
  logic                     out_valid_r;
  logic [COORD_W-1:0]       out_row_r;
  logic [COORD_W-1:0]       out_col_r;
  logic [ACC_W-1:0]         out_acc_r;
  logic                     out_last_r;

  // ---------------------------------------------------------------------
  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_size_r  <= SIZE_RESET;
      plane_count_r <= COUNT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PLANE_SIZE:  plane_size_r  <= cfg_wdata[SIZE_W-1:0];
        REG_PLANE_COUNT: plane_count_r <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped size and count
  always_comb begin
    if (plane_size_r == '0) begin
      size_eff = SIZE_W'(1);
    end else if (plane_size_r > SIZE_W'(MAX_SIZE)) begin
      size_eff = SIZE_W'(MAX_SIZE);
    end else begin
      size_eff = plane_size_r;
    end
    size_p1   = size_eff + SIZE_W'(1);
    count_eff = (plane_count_r == '0) ? COUNT_W'(1) : plane_count_r;
  end

  // ---------------------------------------------------------------------
  // Whole pipeline moves unless a result is blocked by a full output register
  assign adv       = !(s4_res_r && out_valid_r && !out_tready);
  assign in_tready = adv;

  assign in_row   = in_tdata[POS_W-1:0];
  assign in_col   = in_tdata[2*POS_W-1:POS_W];
  assign in_value = in_tdata[2*POS_W+ACC_W-1:2*POS_W];

  // ---------------------------------------------------------------------
  // Stage 1 capture, with line buffer forward from the request ahead
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode_r     <= mode_t'(in_tuser);
      s1_row_r      <= in_row;
      s1_col_r      <= in_col;
      s1_value_r    <= in_value;
      s1_fwd_r      <= lb_we && (lb_waddr == in_col[LB_AW-1:0]);
      s1_fwd_data_r <= lb_wdata;
    end
  end

  // Stage 1 decode
  always_comb begin
    s1_pix      = sat16(s1_value_r);
    s1_in_range = (s1_row_r <= size_p1) && (s1_col_r <= size_p1);
    s1_pix_ok   = 1'b0;
    s1_wt_ok    = 1'b0;
    s1_pre_ok   = 1'b0;
    if (s1_vld_r) begin
      unique case (s1_mode_r)
        MODE_PRELOAD: s1_pre_ok = (s1_row_r < POS_W'(MAX_SIZE)) &&
                                  (s1_col_r < POS_W'(MAX_SIZE));
        MODE_WEIGHT:  s1_wt_ok  = (s1_row_r < POS_W'(TAPS)) && (s1_col_r < POS_W'(TAPS));
        MODE_PIXEL:   s1_pix_ok = s1_in_range;
        default: ;
      endcase
    end
    s1_win        = s1_pix_ok && (s1_row_r >= POS_W'(2)) && (s1_col_r >= POS_W'(2));
    s1_done_plane = (s1_row_r == size_p1) && (s1_col_r == size_p1);
    planes_inc    = {1'b0, planes_done_r} + (COUNT_W+1)'(1);
    s1_is_last    = s1_done_plane && (planes_inc >= {1'b0, count_eff});
    // Pixels address the interior, preloads address the entry directly
    s1_arow = (s1_mode_r == MODE_PIXEL) ? (s1_row_r - POS_W'(2)) : s1_row_r;
    s1_acol = (s1_mode_r == MODE_PIXEL) ? (s1_col_r - POS_W'(2)) : s1_col_r;
    lb_rd   = s1_fwd_r ? s1_fwd_data_r : lb_rdata;
    lb_top  = lb_rd[PIX_W-1:0];
    lb_mid  = lb_rd[2*PIX_W-1:PIX_W];
  end

  // Line buffers: word holds {line 1, line 0} of one column
  assign lb_we    = adv && s1_pix_ok;
  assign lb_waddr = s1_col_r[LB_AW-1:0];
  assign lb_wdata = {s1_pix, lb_mid};

  cmac_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (LB_DEPTH)
  ) u_lb_ram (
    .clk   (clk),
    .we    (lb_we),
    .waddr (lb_waddr),
    .wdata (lb_wdata),
    .re    (adv),
    .raddr (in_col[LB_AW-1:0]),
    .rdata (lb_rdata)
  );

  // Window shift, weight load and plane counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NTAP; i++) begin
        win_r[i]     <= '0;
        weights_r[i] <= '0;
      end
      planes_done_r <= '0;
    end else if (adv) begin
      if (s1_pix_ok) begin
        for (int a = 0; a < TAPS; a++) begin
          for (int b = 0; b < TAPS - 1; b++) begin
            win_r[a*TAPS+b] <= win_r[a*TAPS+b+1];
          end
        end
        win_r[TAPS-1]        <= lb_top;
        win_r[2*TAPS-1]      <= lb_mid;
        win_r[TAPS*TAPS-1]   <= s1_pix;
        if (s1_done_plane) begin
          planes_done_r <= s1_is_last ? '0 : planes_inc[COUNT_W-1:0];
        end
      end
      if (s1_wt_ok) begin
        for (int a = 0; a < TAPS; a++) begin
          for (int b = 0; b < TAPS; b++) begin
            if ((s1_row_r == POS_W'(a)) && (s1_col_r == POS_W'(b))) begin
              weights_r[a*TAPS+b] <= s1_pix;
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: nine products from the window and weights as this pixel left them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_res_r <= 1'b0;
      s2_pre_r <= 1'b0;
    end else if (adv) begin
      s2_res_r <= s1_win;
      s2_pre_r <= s1_pre_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_row_r     <= s1_arow[COORD_W-1:0];
      s2_col_r     <= s1_acol[COORD_W-1:0];
      s2_pre_val_r <= s1_value_r;
      s2_last_r    <= s1_is_last;
    end
  end

  always_comb begin
    for (int i = 0; i < NTAP; i++) begin
      s2_prod[i] = weights_r[i] * win_r[i];
    end
  end

  // Accumulator read issued as the request enters stage 3
  assign acc_raddr = {s2_row_r, s2_col_r};

  // ---------------------------------------------------------------------
  // Stage 3: product sum, accumulator value with forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_res_r <= 1'b0;
      s3_pre_r <= 1'b0;
    end else if (adv) begin
      s3_res_r <= s2_res_r;
      s3_pre_r <= s2_pre_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_row_r      <= s2_row_r;
      s3_col_r      <= s2_col_r;
      s3_pre_val_r  <= s2_pre_val_r;
      s3_last_r     <= s2_last_r;
      for (int i = 0; i < NTAP; i++) begin
        s3_prod_r[i] <= s2_prod[i];
      end
      s3_fwd_r      <= acc_we && (acc_waddr == acc_raddr);
      s3_fwd_data_r <= acc_wdata;
    end
  end

  always_comb begin
    s3_psum = '0;
    for (int i = 0; i < NTAP; i++) begin
      s3_psum = s3_psum + PSUM_W'(s3_prod_r[i]);
    end
    // Newest write wins: stage 4 now, then the one captured at read time
    if (acc_we && (acc_waddr == {s3_row_r, s3_col_r})) begin
      s3_acc_cur = acc_wdata;
    end else if (s3_fwd_r) begin
      s3_acc_cur = s3_fwd_data_r;
    end else begin
      s3_acc_cur = acc_rdata;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: add, saturate, write back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_res_r <= 1'b0;
      s4_pre_r <= 1'b0;
    end else if (adv) begin
      s4_res_r <= s3_res_r;
      s4_pre_r <= s3_pre_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_row_r     <= s3_row_r;
      s4_col_r     <= s3_col_r;
      s4_pre_val_r <= s3_pre_val_r;
      s4_last_r    <= s3_last_r;
      s4_psum_r    <= s3_psum;
      s4_acc_old_r <= s3_acc_cur;
    end
  end

  always_comb begin
    s4_total   = SUM_W'(s4_psum_r) + SUM_W'(s4_acc_old_r);
    s4_acc_new = sat_acc(s4_total);
  end

  assign acc_we    = adv && (s4_res_r || s4_pre_r);
  assign acc_waddr = {s4_row_r, s4_col_r};
  assign acc_wdata = s4_res_r ? s4_acc_new : s4_pre_val_r;

  cmac_ram #(
    .WIDTH (ACC_W),
    .DEPTH (ACC_DEPTH)
  ) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .re    (adv),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  // ---------------------------------------------------------------------
  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s4_res_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s4_res_r) begin
      out_row_r  <= s4_row_r;
      out_col_r  <= s4_col_r;
      out_acc_r  <= s4_acc_new;
      out_last_r <= s4_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_acc_r, out_col_r, out_row_r};
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------------
  // Checks
  `CMAC_ASSERT_NXT(a_run_end_clears, adv && s1_pix_ok && s1_is_last, planes_done_r == '0)
  `CMAC_ASSERT_IMP(a_no_overwrite, adv && s4_res_r, !out_valid_r || out_tready)
  `CMAC_ASSERT_NXT(a_result_shown, adv && s4_res_r, out_valid_r)

endmodule

[dv/multichannel_conv3x3_accumulate_unit_checker.sv]
// Scoreboard for the multichannel 3x3 convolution accumulator: follows every
// register write and accepted request, predicts each accumulator update and
// compares it with the result stream. Depends on cmac_pkg.
`timescale 1ns / 100ps

module multichannel_conv3x3_accumulate_unit_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // row [8:0], col [17:9], value [49:18], zero [55:50]
  input  logic [cmac_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode [1:0]
  input  logic [cmac_pkg::MODE_W-1:0]      in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // out_row [7:0], out_col [15:8], acc_value [47:16]
  input  logic [cmac_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             out_tlast,
  input  logic                             cfg_wr_en,
  input  logic [cmac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cmac_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int unsigned                      fail_count,
  output int unsigned                      update_count,
  output int unsigned                      pending_count
);

  import cmac_pkg::*;

  localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO = -(longint'(1) <<< (ACC_W - 1));

  typedef struct packed {
    logic [COORD_W-1:0]      row;
    logic [COORD_W-1:0]      col;
    logic signed [ACC_W-1:0] acc;
    logic                    last;
  } acc_update_t;

  // Shadow copy of the block state
  logic [SIZE_W-1:0]       plane_size_q;
  logic [COUNT_W-1:0]      plane_count_q;
  logic [COUNT_W-1:0]      planes_done_q;
  logic signed [PIX_W-1:0] kernel   [TAPS][TAPS];
  logic signed [PIX_W-1:0] win      [TAPS][TAPS];
  logic signed [PIX_W-1:0] line_old [LB_DEPTH];
  logic signed [PIX_W-1:0] line_new [LB_DEPTH];
  logic signed [ACC_W-1:0] acc_mem  [ACC_DEPTH];
  acc_update_t             acc_updates_q [$];

  // Q8.8 inputs clamp to the signed 16-bit range
  function automatic logic signed [PIX_W-1:0] clip_q88(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return PIX_W'(v);
  endfunction

  always @(posedge clk) begin : model
    logic [POS_W-1:0]        req_row;
    logic [POS_W-1:0]        req_col;
    logic signed [ACC_W-1:0] req_value;
    logic signed [PIX_W-1:0] pix;
    int unsigned             side;
    int unsigned             planes;
    int unsigned             addr;
    bit                      plane_end;
    bit                      final_plane;
    longint                  total;
    acc_update_t             got;
    acc_update_t             want;

    if (!rst_n) begin
      plane_size_q  = SIZE_RESET;
      plane_count_q = COUNT_RESET;
      planes_done_q = '0;
      for (int a = 0; a < TAPS; a++)
        for (int b = 0; b < TAPS; b++) begin
          kernel[a][b] = '0;
          win[a][b]    = '0;
        end
      for (int i = 0; i < LB_DEPTH; i++) begin
        line_old[i] = '0;
        line_new[i] = '0;
      end
      for (int i = 0; i < ACC_DEPTH; i++) acc_mem[i] = '0;
      acc_updates_q.delete();
      fail_count   = 0;
      update_count = 0;
    end else begin
      // Results first: each one retires the oldest expected update
      if (out_tvalid && out_tready) begin
        got.row  = out_tdata[7:0];
        got.col  = out_tdata[15:8];
        got.acc  = out_tdata[47:16];
        got.last = out_tlast;
        if (acc_updates_q.size() == 0) begin
          $error("unexpected result: row %0d col %0d acc_value %0d", got.row, got.col,
                 got.acc);
          fail_count++;
        end else begin
          want = acc_updates_q.pop_front();
          update_count++;
          if (got.row !== want.row) begin
            $error("out_row mismatch: expected %0d, got %0d", want.row, got.row);
            fail_count++;
          end
          if (got.col !== want.col) begin
            $error("out_col mismatch: expected %0d, got %0d", want.col, got.col);
            fail_count++;
          end
          if (got.acc !== want.acc) begin
            $error("acc_value mismatch: expected %0d, got %0d", want.acc, got.acc);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $error("last mismatch: expected %0d, got %0d", want.last, got.last);
            fail_count++;
          end
        end
      end

      // Register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PLANE_SIZE:  plane_size_q  = cfg_wdata[SIZE_W-1:0];
          REG_PLANE_COUNT: plane_count_q = cfg_wdata[COUNT_W-1:0];
          default: ;
        endcase
      end

      // Accepted requests
      if (in_tvalid && in_tready) begin
        req_row   = in_tdata[8:0];
        req_col   = in_tdata[17:9];
        req_value = in_tdata[49:18];
        case (in_tuser)
          MODE_PRELOAD: begin
            if (req_row < MAX_SIZE && req_col < MAX_SIZE)
              acc_mem[req_row * MAX_SIZE + req_col] = req_value;
          end
          MODE_WEIGHT: begin
            if (req_row < TAPS && req_col < TAPS)
              kernel[req_row][req_col] = clip_q88(req_value);
          end
          MODE_PIXEL: begin
            side   = (plane_size_q == 0) ? 1 :
                     (plane_size_q > MAX_SIZE) ? MAX_SIZE : plane_size_q;
            planes = (plane_count_q == 0) ? 1 : plane_count_q;
            if (req_row <= side + 1 && req_col <= side + 1) begin
              pix = clip_q88(req_value);
              // slide the window one column and pull the new column in
              for (int a = 0; a < TAPS; a++) begin
                win[a][0] = win[a][1];
                win[a][1] = win[a][2];
              end
              win[0][2] = line_old[req_col];
              win[1][2] = line_new[req_col];
              win[2][2] = pix;
              line_old[req_col] = line_new[req_col];
              line_new[req_col] = pix;

              plane_end   = (req_row == side + 1) && (req_col == side + 1);
              final_plane = plane_end && (int'(planes_done_q) + 1 >= planes);

              if (req_row >= 2 && req_col >= 2) begin
                addr  = (req_row - 2) * MAX_SIZE + (req_col - 2);
                total = longint'(acc_mem[addr]);
                for (int a = 0; a < TAPS; a++)
                  for (int b = 0; b < TAPS; b++)
                    total += longint'(kernel[a][b]) * longint'(win[a][b]);
                if (total > ACC_HI) total = ACC_HI;
                else if (total < ACC_LO) total = ACC_LO;
                acc_mem[addr] = ACC_W'(total);
                want.row  = COORD_W'(req_row - 2);
                want.col  = COORD_W'(req_col - 2);
                want.acc  = ACC_W'(total);
                want.last = final_plane;
                acc_updates_q.push_back(want);
              end

              if (plane_end) planes_done_q = final_plane ? '0 : planes_done_q + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
    pending_count = acc_updates_q.size();
  end

endmodule

[dv/multichannel_conv3x3_accumulate_unit_tb.sv]
// Testbench top for the multichannel 3x3 convolution accumulator: clock,
// reset, register settings and request stimulus, the final verdict.
// Depends on cmac_pkg, the unit and multichannel_conv3x3_accumulate_unit_checker.
`timescale 1ns / 100ps

module multichannel_conv3x3_accumulate_unit_tb;
  import cmac_pkg::*;

  localparam int CYCLE_LIMIT   = 300_000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_GOAL   = 600;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic [MODE_W-1:0]      in_tuser  = MODE_PRELOAD;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_PLANE_SIZE;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int unsigned fail_count;
  int unsigned update_count;
  int unsigned pending_count;
  int unsigned cycle_count   = 0;
  int          tx_idle_pct   = 12;
  int          rx_idle_pct   = 52;
  int          cur_size      = 224;
  int          cur_count     = 1;
  int          work_items    = 0;
  int          sent_items    = 0;
  int          setting_count = 0;
  int          plane_runs    = 0;
  // accumulator entries that hold a defined value
  bit          acc_init [ACC_DEPTH];

  multichannel_conv3x3_accumulate_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  multichannel_conv3x3_accumulate_unit_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .update_count  (update_count),
    .pending_count (pending_count)
  );

  always #4 clk = ~clk;

  // Result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Q8.8 sample: mostly modest, sometimes full 16-bit, sometimes beyond
  function automatic logic [31:0] rand_sample();
    logic [15:0] h;
    h = 16'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 32'($urandom_range(0, 4095)) - 32'd2048;
      6, 7, 8: return {{16{h[15]}}, h};
      default: return $urandom;
    endcase
  endfunction

  // Q16.16 accumulator start value, with runs near both rails
  function automatic logic [31:0] rand_acc();
    case ($urandom_range(0, 7))
      0, 1, 2, 3, 4: return 32'($urandom_range(0, 2097152)) - 32'd1048576;
      5: return 32'h7FFF_FFFF - 32'($urandom_range(0, 65535));
      6: return 32'h8000_0000 + 32'($urandom_range(0, 65535));
      default: return $urandom;
    endcase
  endfunction

  function automatic int noise_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 511);
      1: return $urandom_range(0, cur_size + 2);
      2: return cur_size + 1;
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  // One request through the handshake, plus bookkeeping of what it touched
  task automatic send_request(input logic [MODE_W-1:0] mode, input int r, input int c,
                              input logic [31:0] v);
    bit effective;
    effective = 1'b0;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= IN_TDATA_W'({v, POS_W'(c), POS_W'(r)});
    do @(posedge clk); while (!in_tready);
    sent_items++;
    case (mode)
      MODE_PRELOAD: begin
        if (r < MAX_SIZE && c < MAX_SIZE) begin
          acc_init[r * MAX_SIZE + c] = 1'b1;
          effective = 1'b1;
        end
      end
      MODE_WEIGHT: effective = (r < TAPS && c < TAPS);
      MODE_PIXEL: begin
        if (r <= cur_size + 1 && c <= cur_size + 1) begin
          effective = 1'b1;
          if (r >= 2 && c >= 2) acc_init[(r - 2) * MAX_SIZE + c - 2] = 1'b1;
        end
      end
      default: ;
    endcase
    if (effective) work_items++;
  endtask

  // Both registers, written back to back while the block is idle
  task automatic apply_setting(input int size_val, input int count_val);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_PLANE_SIZE;
    cfg_wdata <= CFG_DATA_W'(size_val);
    @(posedge clk);
    cfg_index <= REG_PLANE_COUNT;
    cfg_wdata <= CFG_DATA_W'(count_val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_size  = size_val & 511;
    if (cur_size < 1) cur_size = 1;
    if (cur_size > MAX_SIZE) cur_size = MAX_SIZE;
    cur_count = count_val & 1023;
    if (cur_count == 0) cur_count = 1;
    setting_count++;
  endtask

  // Wait out every expected result, then the pipeline depth
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Preload the interior, then each plane with its kernel in raster order
  task automatic run_planes();
    int span;
    int cut;
    span = cur_size + 2;
    for (int r = 0; r < cur_size; r++)
      for (int c = 0; c < cur_size; c++)
        send_request(MODE_PRELOAD, r, c, rand_acc());
    for (int p = 0; p < cur_count; p++) begin
      for (int a = 0; a < TAPS; a++)
        for (int b = 0; b < TAPS; b++)
          send_request(MODE_WEIGHT, a, b, rand_sample());
      // now and then a plane is abandoned part way through
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, span * span - 1) : span * span;
      for (int k = 0; k < cut; k++)
        send_request(MODE_PIXEL, k / span, k % span, rand_sample());
      plane_runs++;
    end
  endtask

  // Any mode, any position; an untouched accumulator entry is preloaded first
  task automatic send_noise();
    logic [MODE_W-1:0] mode;
    int                r;
    int                c;
    logic [31:0]       v;
    case ($urandom_range(0, 7))
      0: mode = MODE_PRELOAD;
      1: mode = MODE_WEIGHT;
      2: mode = MODE_UNUSED;
      default: mode = MODE_PIXEL;
    endcase
    r = noise_coord();
    c = noise_coord();
    v = $urandom_range(0, 1) ? $urandom : rand_sample();
    if (mode == MODE_PIXEL && r >= 2 && c >= 2 && r <= cur_size + 1 && c <= cur_size + 1 &&
        !acc_init[(r - 2) * MAX_SIZE + c - 2])
      send_request(MODE_PRELOAD, r - 2, c - 2, rand_acc());
    send_request(mode, r, c, v);
  endtask

  // Watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d results outstanding",
             cycle_count, pending_count);
    $display("** multichannel_conv3x3_accumulate_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] extreme_vals [9];
    int          wide_sizes [3];
    int          fixed_size [6];
    int          fixed_count [6];
    int          phase_idx;
    extreme_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_7FFF, 32'hFFFF_8000,
                     32'h0000_0100, 32'hFFFF_FF00, 32'h0001_0000, 32'hFFFE_FFFF,
                     32'h0000_0001};
    wide_sizes   = '{MAX_SIZE, MAX_SIZE + 1, 511};
    fixed_size   = '{3, 0, MAX_SIZE, 511, 6, 2};
    fixed_count  = '{2, 3, 0, 1023, 1, 512};
    phase_idx    = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill both line buffer rows across the widest plane before anything else
    apply_setting(MAX_SIZE, 1);
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < LB_DEPTH; c++)
        send_request(MODE_PIXEL, r, c, rand_sample());
    settle();

    // Directed: 1x1 plane, zero plane count, rail values, ignored requests
    apply_setting(1, 0);
    send_request(MODE_PRELOAD, 0, 0, 32'h7FFF_0000);
    send_request(MODE_PRELOAD, MAX_SIZE, 3, 32'h0000_0001);
    send_request(MODE_PRELOAD, MAX_SIZE - 1, MAX_SIZE - 1, 32'h8000_0000);
    for (int k = 0; k < TAPS * TAPS; k++)
      send_request(MODE_WEIGHT, k / TAPS, k % TAPS, extreme_vals[k]);
    send_request(MODE_WEIGHT, TAPS, 0, 32'h0000_0005);
    send_request(MODE_UNUSED, 1, 1, 32'hFFFF_FFFF);
    for (int k = 0; k < TAPS * TAPS; k++)
      send_request(MODE_PIXEL, k / TAPS, k % TAPS, extreme_vals[TAPS * TAPS - 1 - k]);
    send_request(MODE_PIXEL, 3, 1, 32'h0000_0100);
    settle();

    // Random phases: well-formed runs with noise, a few wide noise-only phases
    work_items = 0;
    while (work_items < RANDOM_GOAL) begin
      if (work_items < RANDOM_GOAL / 3) begin
        tx_idle_pct = 12;
        rx_idle_pct <= 52;
      end else if (work_items < 2 * RANDOM_GOAL / 3) begin
        tx_idle_pct = 52;
        rx_idle_pct <= 12;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      if (phase_idx < 6)
        apply_setting(fixed_size[phase_idx], fixed_count[phase_idx]);
      else if ($urandom_range(0, 7) == 0)
        apply_setting(wide_sizes[$urandom_range(0, 2)], $urandom_range(0, 1023));
      else
        apply_setting($urandom_range(0, 6), $urandom_range(0, 4));
      phase_idx++;
      if (cur_size <= 16 && cur_count <= 8) begin
        repeat ($urandom_range(1, 2)) run_planes();
        repeat ($urandom_range(0, 8)) send_noise();
      end else begin
        repeat ($urandom_range(60, 80)) send_noise();
      end
      settle();
    end

    $display("Covered %0d requests over %0d register settings and %0d raster planes;",
             sent_items, setting_count, plane_runs);
    $display("compared %0d accumulator updates, %0d failures", update_count, fail_count);
    if (fail_count == 0 && pending_count == 0)
      $display("** multichannel_conv3x3_accumulate_unit: PASSED **");
    else
      $display("** multichannel_conv3x3_accumulate_unit: FAILED **");
    $finish;
  end

endmodule

[multichannel_conv3x3_accumulate_unit.f]
+incdir+rtl
rtl/cmac_pkg.sv
rtl/cmac_ram.sv
rtl/multichannel_conv3x3_accumulate_unit.sv
dv/multichannel_conv3x3_accumulate_unit_checker.sv
dv/multichannel_conv3x3_accumulate_unit_tb.sv
